// ----- rtl/ktsmp_pkg.sv -----
package ktsmp_pkg;

  // Default sizes
  localparam int unsigned CONST_DEPTH_DEF   = 64;
  localparam int unsigned CHANNEL_DEPTH_DEF = 64;
  localparam int unsigned SAMPLE_DEPTH_DEF  = 4096;
  localparam int unsigned MAX_BONES_DEF     = 256;
  localparam int unsigned FRAC_BITS_DEF     = 8;

  // Field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SLOT_W  = 12;
  localparam int unsigned BONE_W  = 8;
  localparam int unsigned FIRST_W = 12;
  localparam int unsigned TOTAL_W = 13;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned SRC_W   = 3;
  // first + key offset
  localparam int unsigned KADDR_W = 14;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT  = 1'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_CONST   = 2'd0,
    KIND_LOAD_CHANNEL = 2'd1,
    KIND_LOAD_SAMPLE  = 2'd2,
    KIND_QUERY        = 2'd3
  } kind_e;

  typedef enum logic [SRC_W-1:0] {
    SRC_CONST     = 3'd0,
    SRC_LERP      = 3'd1,
    SRC_SINGLE    = 3'd2,
    SRC_FALLBACK  = 3'd3,
    SRC_INDEX_ERR = 3'd4
  } source_e;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [SLOT_W-1:0]         slot;
    logic [BONE_W-1:0]         bone;
    logic [FIRST_W-1:0]        first_sample;
    logic [TOTAL_W-1:0]        sample_total;
    logic signed [VAL_W-1:0]   frame;
    logic signed [VAL_W-1:0]   value_x;
    logic signed [VAL_W-1:0]   value_y;
    logic signed [VAL_W-1:0]   value_z;
  } in_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;
    logic signed [VAL_W-1:0] out_z;
    logic [SRC_W-1:0]        source;
  } out_rsp_t;

  typedef struct packed {
    logic [BONE_W-1:0] bone;
    logic [VAL_W-1:0]  x;
    logic [VAL_W-1:0]  y;
    logic [VAL_W-1:0]  z;
  } const_ent_t;

  typedef struct packed {
    logic [BONE_W-1:0]  bone;
    logic [FIRST_W-1:0] first;
    logic [TOTAL_W-1:0] total;
  } chan_ent_t;

  typedef struct packed {
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] z;
  } sample_ent_t;

  typedef enum logic [1:0] {
    RES_CONST,
    RES_FALLBACK,
    RES_INDEX_ERR,
    RES_SAMPLE
  } res_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CSCAN,
    ST_HSCAN,
    ST_CLAMP,
    ST_ADDR,
    ST_RDA,
    ST_RDB,
    ST_MUL,
    ST_SUM,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic     in_take;
    logic     scan_rst;
    logic     cscan;
    logic     hscan;
    logic     chan_take;
    logic     clamp;
    logic     addr;
    logic     rd_a;
    logic     rd_b;
    logic     mul;
    logic     res_load;
    res_sel_e res_sel;
    logic     out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bone_oob;
    logic cmatch;
    logic cdone;
    logic hmatch;
    logic hdone;
    logic idx_err;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/ktsmp_ctrl.sv -----
module ktsmp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [ktsmp_pkg::KIND_W-1:0] in_kind_i,
  input  ktsmp_pkg::dp_status_t  status_i,
  output ktsmp_pkg::ctrl_cmd_t   cmd_o,
  output logic                   in_stall_o
);

  ktsmp_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ktsmp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.res_sel = ktsmp_pkg::RES_FALLBACK;
    in_stall_o    = 1'b1;

    unique case (state_q)
      ktsmp_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.in_take = 1'b1;
          if (in_kind_i == ktsmp_pkg::KIND_QUERY) begin
            cmd_o.scan_rst = 1'b1;
            state_d        = ktsmp_pkg::ST_CSCAN;
          end
        end
      end

      // constant table, one entry issued per cycle
      ktsmp_pkg::ST_CSCAN: begin
        cmd_o.cscan = 1'b1;
        priority if (status_i.bone_oob) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = ktsmp_pkg::RES_FALLBACK;
          state_d        = ktsmp_pkg::ST_EMIT;
        end else if (status_i.cmatch) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = ktsmp_pkg::RES_CONST;
          state_d        = ktsmp_pkg::ST_EMIT;
        end else if (status_i.cdone) begin
          cmd_o.scan_rst = 1'b1;
          state_d        = ktsmp_pkg::ST_HSCAN;
        end
      end

      // channel table
      ktsmp_pkg::ST_HSCAN: begin
        cmd_o.hscan = 1'b1;
        priority if (status_i.hmatch) begin
          cmd_o.chan_take = 1'b1;
          state_d         = ktsmp_pkg::ST_CLAMP;
        end else if (status_i.hdone) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = ktsmp_pkg::RES_FALLBACK;
          state_d        = ktsmp_pkg::ST_EMIT;
        end
      end

      ktsmp_pkg::ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = ktsmp_pkg::ST_ADDR;
      end

      ktsmp_pkg::ST_ADDR: begin
        cmd_o.addr = 1'b1;
        state_d    = ktsmp_pkg::ST_RDA;
      end

      ktsmp_pkg::ST_RDA: begin
        if (status_i.idx_err) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = ktsmp_pkg::RES_INDEX_ERR;
          state_d        = ktsmp_pkg::ST_EMIT;
        end else begin
          cmd_o.rd_a = 1'b1;
          state_d    = ktsmp_pkg::ST_RDB;
        end
      end

      ktsmp_pkg::ST_RDB: begin
        cmd_o.rd_b = 1'b1;
        state_d    = ktsmp_pkg::ST_MUL;
      end

      ktsmp_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ktsmp_pkg::ST_SUM;
      end

      ktsmp_pkg::ST_SUM: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = ktsmp_pkg::RES_SAMPLE;
        state_d        = ktsmp_pkg::ST_EMIT;
      end

      // wait for room in the output register
      ktsmp_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ktsmp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ktsmp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/ktsmp_dp.sv -----
module ktsmp_dp #(
  parameter int unsigned CONST_DEPTH   = ktsmp_pkg::CONST_DEPTH_DEF,
  parameter int unsigned CHANNEL_DEPTH = ktsmp_pkg::CHANNEL_DEPTH_DEF,
  parameter int unsigned SAMPLE_DEPTH  = ktsmp_pkg::SAMPLE_DEPTH_DEF,
  parameter int unsigned MAX_BONES     = ktsmp_pkg::MAX_BONES_DEF,
  parameter int unsigned FRAC_BITS     = ktsmp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ktsmp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ktsmp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  ktsmp_pkg::in_req_t                  in_req_i,
  input  ktsmp_pkg::ctrl_cmd_t                cmd_i,
  output ktsmp_pkg::dp_status_t               status_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ktsmp_pkg::out_rsp_t                 out_rsp_o
);

  localparam int unsigned CAW  = (CONST_DEPTH > 1) ? $clog2(CONST_DEPTH) : 1;
  localparam int unsigned HAW  = (CHANNEL_DEPTH > 1) ? $clog2(CHANNEL_DEPTH) : 1;
  localparam int unsigned SAW  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int unsigned IW   = ((CAW > HAW) ? CAW : HAW) + 1;
  localparam int unsigned VW   = ktsmp_pkg::VAL_W;
  localparam int unsigned TW   = ktsmp_pkg::TOTAL_W;
  localparam int unsigned KW   = ktsmp_pkg::KADDR_W;
  // (b - a) is VW+1 bits, fraction is FRAC_BITS+1 bits signed
  localparam int unsigned PW   = VW + FRAC_BITS + 2;

  // Memories
  ktsmp_pkg::const_ent_t  const_mem  [CONST_DEPTH];
  ktsmp_pkg::chan_ent_t   chan_mem   [CHANNEL_DEPTH];
  ktsmp_pkg::sample_ent_t sample_mem [SAMPLE_DEPTH];

  // Configuration
  logic [ktsmp_pkg::CFG_DATA_W-1:0] const_count_q, chan_count_q;

  // Query and scan state
  ktsmp_pkg::in_req_t     qry_q;
  logic [IW-1:0]          idx_q;
  logic                   rd_valid_q;
  ktsmp_pkg::const_ent_t  crd_q;
  ktsmp_pkg::chan_ent_t   hrd_q;
  logic [ktsmp_pkg::FIRST_W-1:0] ch_first_q;
  logic [TW-1:0]          ch_total_q;

  // Interpolation state
  logic [VW-1:0]          cl_q;
  logic [FRAC_BITS-1:0]   t_q;
  logic [SAW-1:0]         sa_addr_q, sb_addr_q;
  logic                   idx_err_q;
  ktsmp_pkg::sample_ent_t srd_q, sa_q;
  logic signed [PW-1:0]   prod_x_q, prod_y_q, prod_z_q;

  ktsmp_pkg::out_rsp_t    res_q, out_rsp_q;
  logic                   out_valid_q;

  logic c_more, h_more, c_issue, h_issue;
  logic take_load;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      const_count_q <= '0;
      chan_count_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ktsmp_pkg::CFG_CONSTANT_COUNT: const_count_q <= cfg_wdata_i;
        ktsmp_pkg::CFG_CHANNEL_COUNT:  chan_count_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Scan issue conditions; counts saturate at the table depth
  assign c_more  = (32'(idx_q) < 32'(const_count_q)) && (32'(idx_q) < CONST_DEPTH);
  assign h_more  = (32'(idx_q) < 32'(chan_count_q)) && (32'(idx_q) < CHANNEL_DEPTH);
  assign c_issue = cmd_i.cscan && c_more;
  assign h_issue = cmd_i.hscan && h_more;
  assign take_load = cmd_i.in_take;

  // Scan counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      rd_valid_q <= 1'b0;
    end else if (cmd_i.scan_rst) begin
      idx_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= c_issue || h_issue;
      if (c_issue || h_issue) begin
        idx_q <= idx_q + IW'(1);
      end
    end
  end

  // Constant table: load writes, scan reads
  always_ff @(posedge clk_i) begin
    if (take_load && in_req_i.kind == ktsmp_pkg::KIND_LOAD_CONST &&
        32'(in_req_i.slot) < CONST_DEPTH) begin
      const_mem[CAW'(in_req_i.slot)] <= {in_req_i.bone, in_req_i.value_x,
                                         in_req_i.value_y, in_req_i.value_z};
    end
    if (c_issue) begin
      crd_q <= const_mem[CAW'(idx_q)];
    end
  end

  // Channel table
  always_ff @(posedge clk_i) begin
    if (take_load && in_req_i.kind == ktsmp_pkg::KIND_LOAD_CHANNEL &&
        32'(in_req_i.slot) < CHANNEL_DEPTH) begin
      chan_mem[HAW'(in_req_i.slot)] <= {in_req_i.bone, in_req_i.first_sample,
                                        in_req_i.sample_total};
    end
    if (h_issue) begin
      hrd_q <= chan_mem[HAW'(idx_q)];
    end
  end

  // Sample store, one read port shared by both keys
  always_ff @(posedge clk_i) begin
    if (take_load && in_req_i.kind == ktsmp_pkg::KIND_LOAD_SAMPLE &&
        32'(in_req_i.slot) < SAMPLE_DEPTH) begin
      sample_mem[SAW'(in_req_i.slot)] <= {in_req_i.value_x, in_req_i.value_y,
                                          in_req_i.value_z};
    end
    if (cmd_i.rd_a) begin
      srd_q <= sample_mem[sa_addr_q];
    end else if (cmd_i.rd_b) begin
      srd_q <= sample_mem[sb_addr_q];
    end
  end

  // Query latch and channel capture
  always_ff @(posedge clk_i) begin
    if (take_load && in_req_i.kind == ktsmp_pkg::KIND_QUERY) begin
      qry_q <= in_req_i;
    end
    if (cmd_i.chan_take) begin
      ch_first_q <= hrd_q.first;
      ch_total_q <= hrd_q.total;
    end
  end

  // Frame clamp to 0 .. (total-1) in Q.FRAC_BITS
  logic [VW-1:0] hi;
  assign hi = VW'(ch_total_q - TW'(1)) << FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clamp) begin
      if (qry_q.frame[VW-1]) begin
        cl_q <= '0;
      end else if (VW'(qry_q.frame) > hi) begin
        cl_q <= hi;
      end else begin
        cl_q <= VW'(qry_q.frame);
      end
    end
  end

  // Key addresses and range check
  logic [TW-1:0] i0, i1;
  logic [KW-1:0] ka, kb;
  assign i0 = TW'(cl_q >> FRAC_BITS);
  assign i1 = (i0 == ch_total_q - TW'(1)) ? i0 : i0 + TW'(1);
  assign ka = KW'(ch_first_q) + KW'(i0);
  assign kb = KW'(ch_first_q) + KW'(i1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_err_q <= 1'b0;
    end else if (cmd_i.addr) begin
      idx_err_q <= (32'(ka) >= SAMPLE_DEPTH) || (32'(kb) >= SAMPLE_DEPTH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr) begin
      t_q       <= cl_q[FRAC_BITS-1:0];
      sa_addr_q <= SAW'(ka);
      sb_addr_q <= SAW'(kb);
    end
    // first key arrives while the second is being read
    if (cmd_i.rd_b) begin
      sa_q <= srd_q;
    end
  end

  // (b - a) * t, three lanes
  logic signed [VW:0]   dx, dy, dz;
  logic signed [PW-1:0] tt;
  assign dx = $signed({srd_q.x[VW-1], srd_q.x}) - $signed({sa_q.x[VW-1], sa_q.x});
  assign dy = $signed({srd_q.y[VW-1], srd_q.y}) - $signed({sa_q.y[VW-1], sa_q.y});
  assign dz = $signed({srd_q.z[VW-1], srd_q.z}) - $signed({sa_q.z[VW-1], sa_q.z});
  assign tt = PW'($signed({1'b0, t_q}));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_x_q <= PW'(dx) * tt;
      prod_y_q <= PW'(dy) * tt;
      prod_z_q <= PW'(dz) * tt;
    end
  end

  // a + floor(prod / 2^FRAC_BITS)
  logic signed [PW-1:0] shx, shy, shz;
  assign shx = prod_x_q >>> FRAC_BITS;
  assign shy = prod_y_q >>> FRAC_BITS;
  assign shz = prod_z_q >>> FRAC_BITS;

  // Result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      unique case (cmd_i.res_sel)
        ktsmp_pkg::RES_CONST: begin
          res_q <= {crd_q.x, crd_q.y, crd_q.z, ktsmp_pkg::SRC_CONST};
        end
        ktsmp_pkg::RES_FALLBACK: begin
          res_q <= {qry_q.value_x, qry_q.value_y, qry_q.value_z,
                    ktsmp_pkg::SRC_FALLBACK};
        end
        ktsmp_pkg::RES_INDEX_ERR: begin
          res_q <= {qry_q.value_x, qry_q.value_y, qry_q.value_z,
                    ktsmp_pkg::SRC_INDEX_ERR};
        end
        ktsmp_pkg::RES_SAMPLE: begin
          res_q.out_x  <= sa_q.x + VW'(shx);
          res_q.out_y  <= sa_q.y + VW'(shy);
          res_q.out_z  <= sa_q.z + VW'(shz);
          res_q.source <= (ch_total_q == TW'(1)) ? ktsmp_pkg::SRC_SINGLE
                                                 : ktsmp_pkg::SRC_LERP;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_rsp_q <= res_q;
    end
  end

  // Status
  always_comb begin
    status_o          = '0;
    status_o.bone_oob = 32'(qry_q.bone) >= MAX_BONES;
    status_o.cmatch   = rd_valid_q && (crd_q.bone == qry_q.bone);
    status_o.cdone    = !rd_valid_q && !c_more;
    status_o.hmatch   = rd_valid_q && (hrd_q.bone == qry_q.bone) && (hrd_q.total != '0);
    status_o.hdone    = !rd_valid_q && !h_more;
    status_o.idx_err  = idx_err_q;
    status_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ----- rtl/keyframe_track_sampler_top.sv -----
// Keyframe track sampler for one xyz stream (values Q16.16, frame Q24.8).
// Input channel (in_valid_i / in_stall_o / in_req_i): load requests fill the
// constant table, the channel table or the sample store; a query request
// returns one result on the output channel (out_valid_o / out_stall_i /
// out_rsp_o). Loads return nothing and leave the block idle.
// Configuration (cfg_we_i / cfg_index_i / cfg_wdata_i) sets the number of
// constant and channel entries scanned; write only while the block is idle.
// A query scans the constant table, then, with no constant match, the channel
// table; a keyed result then passes the clamp, address, key read, multiply and
// sum steps. The scans run through the single read port of each table, one
// entry per cycle, and the two keys are read in turn through the one port of
// the sample store.
// One request is worked on at a time; in_stall_o is high while a query is
// in progress. The result sits in an output register; a new request is taken
// while it waits, but a finished query holds until the register frees.
// Reset clears the counts, the control and the output valid; table contents
// are undefined until loaded.
module keyframe_track_sampler_top #(
  parameter int unsigned CONST_DEPTH   = ktsmp_pkg::CONST_DEPTH_DEF,
  parameter int unsigned CHANNEL_DEPTH = ktsmp_pkg::CHANNEL_DEPTH_DEF,
  parameter int unsigned SAMPLE_DEPTH  = ktsmp_pkg::SAMPLE_DEPTH_DEF,
  parameter int unsigned MAX_BONES     = ktsmp_pkg::MAX_BONES_DEF,
  parameter int unsigned FRAC_BITS     = ktsmp_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ktsmp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ktsmp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ktsmp_pkg::in_req_t               in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ktsmp_pkg::out_rsp_t              out_rsp_o
);

  ktsmp_pkg::ctrl_cmd_t  cmd;
  ktsmp_pkg::dp_status_t status;

  // Sequencer
  ktsmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_req_i.kind),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Tables, interpolation and output register
  ktsmp_dp #(
    .CONST_DEPTH   (CONST_DEPTH),
    .CHANNEL_DEPTH (CHANNEL_DEPTH),
    .SAMPLE_DEPTH  (SAMPLE_DEPTH),
    .MAX_BONES     (MAX_BONES),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import ktsmp_pkg::*;

  localparam int unsigned CONST_DEPTH   = CONST_DEPTH_DEF;
  localparam int unsigned CHANNEL_DEPTH = CHANNEL_DEPTH_DEF;
  localparam int unsigned SAMPLE_DEPTH  = SAMPLE_DEPTH_DEF;
  localparam int unsigned FRAC          = FRAC_BITS_DEF;
  localparam int unsigned IDLE_PCT      = 24;
  // long enough for the slowest query to finish
  localparam int unsigned SETTLE_CYCLES  = 160;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_req_t               in_req_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_rsp_t              out_rsp_o;

  keyframe_track_sampler_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the block's tables and counts
  const_ent_t  const_tab  [CONST_DEPTH];
  chan_ent_t   chan_tab   [CHANNEL_DEPTH];
  sample_ent_t sample_tab [SAMPLE_DEPTH];
  bit          const_done [CONST_DEPTH];
  bit          chan_done  [CHANNEL_DEPTH];
  bit          sample_done[SAMPLE_DEPTH];
  int unsigned const_limit = 0;
  int unsigned chan_limit  = 0;

  out_rsp_t    due_samples[$];
  out_rsp_t    want;
  int unsigned fail_count = 0;
  bit          quiet = 1'b0;

  // Linear blend of two Q16.16 keys, floor rounding, exact
  function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] ka,
                                             input logic [VAL_W-1:0] kb,
                                             input longint t);
    longint sa;
    longint sb;
    longint sum;
    sa  = longint'($signed(ka));
    sb  = longint'($signed(kb));
    sum = sa + (((sb - sa) * t) >>> FRAC);
    return sum[VAL_W-1:0];
  endfunction

  // Expected sample for a query; also reports the key addresses it reads
  function automatic void predict_sample(input in_req_t q, output out_rsp_t rsp,
                                         output int ka, output int kb);
    int unsigned n;
    longint fr;
    longint top;
    longint cl;
    longint t;
    longint i0;
    longint i1;
    longint tot;
    longint a;
    longint b;
    rsp.out_x  = q.value_x;
    rsp.out_y  = q.value_y;
    rsp.out_z  = q.value_z;
    rsp.source = SRC_FALLBACK;
    ka = -1;
    kb = -1;
    n = (const_limit < CONST_DEPTH) ? const_limit : CONST_DEPTH;
    for (int i = 0; i < n; i++) begin
      if (const_tab[i].bone == q.bone) begin
        rsp.out_x  = const_tab[i].x;
        rsp.out_y  = const_tab[i].y;
        rsp.out_z  = const_tab[i].z;
        rsp.source = SRC_CONST;
        return;
      end
    end
    n = (chan_limit < CHANNEL_DEPTH) ? chan_limit : CHANNEL_DEPTH;
    for (int i = 0; i < n; i++) begin
      if (chan_tab[i].bone == q.bone && chan_tab[i].total != 0) begin
        tot = chan_tab[i].total;
        if (tot == 1) begin
          ka = chan_tab[i].first;
          rsp.out_x  = sample_tab[ka].x;
          rsp.out_y  = sample_tab[ka].y;
          rsp.out_z  = sample_tab[ka].z;
          rsp.source = SRC_SINGLE;
          return;
        end
        // clamp frame to the key range, then split index and fraction
        fr  = longint'(q.frame);
        top = (tot - 1) << FRAC;
        cl  = (fr < 0) ? 0 : ((fr > top) ? top : fr);
        i0  = cl >> FRAC;
        t   = cl & ((longint'(1) << FRAC) - 1);
        i1  = (i0 + 1 < tot - 1) ? i0 + 1 : tot - 1;
        a   = longint'(chan_tab[i].first) + i0;
        b   = longint'(chan_tab[i].first) + i1;
        if (a < SAMPLE_DEPTH) ka = int'(a);
        if (b < SAMPLE_DEPTH) kb = int'(b);
        if (a >= SAMPLE_DEPTH || b >= SAMPLE_DEPTH) begin
          rsp.source = SRC_INDEX_ERR;
          return;
        end
        rsp.out_x  = blend(sample_tab[a].x, sample_tab[b].x, t);
        rsp.out_y  = blend(sample_tab[a].y, sample_tab[b].y, t);
        rsp.out_z  = blend(sample_tab[a].z, sample_tab[b].z, t);
        rsp.source = SRC_LERP;
        return;
      end
    end
  endfunction

  // Apply an accepted request to the shadow state
  function automatic void absorb(input in_req_t r);
    out_rsp_t rsp;
    int ka;
    int kb;
    case (kind_e'(r.kind))
      KIND_LOAD_CONST: begin
        if (r.slot < CONST_DEPTH) begin
          const_tab[r.slot]  = {r.bone, r.value_x, r.value_y, r.value_z};
          const_done[r.slot] = 1'b1;
        end
      end
      KIND_LOAD_CHANNEL: begin
        if (r.slot < CHANNEL_DEPTH) begin
          chan_tab[r.slot]  = {r.bone, r.first_sample, r.sample_total};
          chan_done[r.slot] = 1'b1;
        end
      end
      KIND_LOAD_SAMPLE: begin
        sample_tab[r.slot]  = {r.value_x, r.value_y, r.value_z};
        sample_done[r.slot] = 1'b1;
      end
      default: begin
        predict_sample(r, rsp, ka, kb);
        due_samples.push_back(rsp);
      end
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_req_t noise_req();
    in_req_t r;
    r.kind         = $urandom_range(0, 3);
    r.slot         = $urandom_range(0, 4095);
    r.bone         = $urandom_range(0, 255);
    r.first_sample = $urandom_range(0, 4095);
    r.sample_total = $urandom_range(0, 4096);
    r.frame        = $urandom;
    r.value_x      = pick_value();
    r.value_y      = pick_value();
    r.value_z      = pick_value();
    return r;
  endfunction

  function automatic in_req_t mk_const(input int unsigned slot, input int unsigned bone);
    in_req_t r;
    r      = noise_req();
    r.kind = KIND_LOAD_CONST;
    r.slot = slot;
    r.bone = bone;
    return r;
  endfunction

  function automatic in_req_t mk_channel(input int unsigned slot, input int unsigned bone,
                                         input int unsigned first, input int unsigned total);
    in_req_t r;
    r              = noise_req();
    r.kind         = KIND_LOAD_CHANNEL;
    r.slot         = slot;
    r.bone         = bone;
    r.first_sample = first;
    r.sample_total = total;
    return r;
  endfunction

  function automatic in_req_t mk_sample(input int unsigned slot, input logic [VAL_W-1:0] x,
                                        input logic [VAL_W-1:0] y, input logic [VAL_W-1:0] z);
    in_req_t r;
    r         = noise_req();
    r.kind    = KIND_LOAD_SAMPLE;
    r.slot    = slot;
    r.value_x = x;
    r.value_y = y;
    r.value_z = z;
    return r;
  endfunction

  function automatic in_req_t mk_query(input int unsigned bone, input logic [VAL_W-1:0] frame);
    in_req_t r;
    r       = noise_req();
    r.kind  = KIND_QUERY;
    r.bone  = bone;
    r.frame = frame;
    return r;
  endfunction

  // Some constants use bones 0..5; bones 6..11 mostly reach the channels
  function automatic int unsigned pick_const_bone();
    return ($urandom_range(0, 99) < 30) ? $urandom_range(0, 5) : $urandom_range(0, 255);
  endfunction

  function automatic int unsigned pick_bone();
    return ($urandom_range(0, 99) < 75) ? $urandom_range(0, 11) : $urandom_range(0, 255);
  endfunction

  function automatic in_req_t random_channel(input int unsigned slot);
    int unsigned pct;
    int unsigned total;
    int unsigned first;
    pct = $urandom_range(0, 99);
    if (pct < 8)       total = 0;
    else if (pct < 30) total = 1;
    else if (pct < 85) total = $urandom_range(2, 8);
    else if (pct < 95) total = $urandom_range(9, 4096);
    else               total = 4096;
    // mostly keys inside the store, some running past its end
    if ($urandom_range(0, 99) < 80)
      first = $urandom_range(0, SAMPLE_DEPTH - ((total == 0) ? 1 : total));
    else
      first = $urandom_range(0, 4095);
    return mk_channel(slot, pick_bone(), first, total);
  endfunction

  function automatic logic [VAL_W-1:0] pick_frame();
    int unsigned pct;
    pct = $urandom_range(0, 99);
    if (pct < 55) return $urandom_range(0, 9 << FRAC);
    if (pct < 65) return -$urandom_range(1, 1024);
    if (pct < 80) return $urandom;
    if (pct < 95) return $urandom_range(0, 4096 << FRAC);
    return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
  endfunction

  // Offer one request; returns at the edge where it is taken
  task automatic send_req(input in_req_t req);
    int unsigned gap;
    gap = 0;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    absorb(req);
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_samples.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then give a trailing load time to finish
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_counts(input logic [CFG_DATA_W-1:0] ccount,
                            input logic [CFG_DATA_W-1:0] hcount);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_CONSTANT_COUNT;
    cfg_wdata_i <= ccount;
    @(posedge clk_i);
    const_limit = ccount;
    cfg_index_i <= CFG_CHANNEL_COUNT;
    cfg_wdata_i <= hcount;
    @(posedge clk_i);
    chan_limit = hcount;
    cfg_we_i <= 1'b0;
  endtask

  // Every entry a query can scan must hold data first
  task automatic fill_tables();
    for (int s = 0; s < CONST_DEPTH && s < const_limit; s++)
      if (!const_done[s]) send_req(mk_const(s, pick_const_bone()));
    for (int s = 0; s < CHANNEL_DEPTH && s < chan_limit; s++)
      if (!chan_done[s]) send_req(random_channel(s));
  endtask

  // Query with its keys loaded beforehand when they were never written
  task automatic random_query();
    in_req_t  q;
    out_rsp_t rsp;
    int       ka;
    int       kb;
    q = mk_query(pick_bone(), pick_frame());
    predict_sample(q, rsp, ka, kb);
    if (ka >= 0 && !sample_done[ka]) send_req(mk_sample(ka, pick_value(), pick_value(),
                                                        pick_value()));
    if (kb >= 0 && !sample_done[kb]) send_req(mk_sample(kb, pick_value(), pick_value(),
                                                        pick_value()));
    send_req(q);
  endtask

  task automatic run_phase(input int unsigned ccount, input int unsigned hcount,
                           input int unsigned items, input bit calm);
    int unsigned sent;
    int unsigned pct;
    int unsigned slot;
    settle();
    set_counts(ccount, hcount);
    fill_tables();
    quiet = calm;
    sent  = 0;
    while (sent < items) begin
      pct = $urandom_range(0, 99);
      if (pct < 2) begin
        wait_results();
      end else if (pct < 57) begin
        random_query();
        sent++;
      end else if (pct < 70) begin
        slot = ($urandom_range(0, 9) != 0) ? $urandom_range(0, CONST_DEPTH - 1)
                                           : $urandom_range(CONST_DEPTH, 4095);
        send_req(mk_const(slot, pick_const_bone()));
        if (slot < CONST_DEPTH) sent++;
      end else if (pct < 83) begin
        slot = ($urandom_range(0, 9) != 0) ? $urandom_range(0, CHANNEL_DEPTH - 1)
                                           : $urandom_range(CHANNEL_DEPTH, 4095);
        send_req(random_channel(slot));
        if (slot < CHANNEL_DEPTH) sent++;
      end else begin
        send_req(mk_sample($urandom_range(0, 4095), pick_value(), pick_value(),
                           pick_value()));
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  // Nothing scanned yet: every query falls back
  task automatic test_empty_tables();
    in_req_t q;
    set_counts(0, 0);
    q = mk_query(0, 32'h0000_0000);
    q.value_x = 32'h8000_0000;
    q.value_y = 32'h8000_0000;
    q.value_z = 32'h8000_0000;
    send_req(q);
    q = mk_query(255, 32'hffff_ffff);
    q.value_x = 32'h7fff_ffff;
    q.value_y = 32'h7fff_ffff;
    q.value_z = 32'h7fff_ffff;
    send_req(q);
  endtask

  // Slots past the table depth are dropped
  task automatic test_ignored_loads();
    send_req(mk_const(CONST_DEPTH, 3));
    send_req(mk_const(4095, 3));
    send_req(mk_channel(CHANNEL_DEPTH, 3, 0, 1));
    send_req(mk_channel(4095, 3, 0, 1));
  endtask

  // Two constants on one bone: the first one wins
  task automatic test_constant_hit();
    send_req(mk_const(0, 7));
    send_req(mk_const(1, 7));
    settle();
    set_counts(2, 0);
    send_req(mk_query(7, $urandom));
    send_req(mk_query(8, $urandom));
  endtask

  // Empty channel, single key, clamping, blend extremes, index error
  task automatic test_channel_paths();
    send_req(mk_sample(4095, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000));
    send_req(mk_sample(0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
    send_req(mk_sample(1, 32'h8000_0000, 32'h0000_0000, 32'h1234_5678));
    send_req(mk_sample(2, 32'h7fff_ffff, 32'hffff_ffff, 32'h0001_0000));
    send_req(mk_channel(0, 9, 0, 0));
    send_req(mk_channel(1, 9, 4095, 1));
    send_req(mk_channel(2, 10, 0, 3));
    send_req(mk_channel(3, 11, 4095, 2));
    send_req(mk_channel(4, 13, 0, 4096));
    settle();
    set_counts(2, 5);
    send_req(mk_query(9, $urandom));
    send_req(mk_query(10, 32'h8000_0000));
    send_req(mk_query(10, 32'h0000_0180));
    send_req(mk_query(10, 32'h7fff_ffff));
    send_req(mk_query(11, 32'h0000_0000));
    send_req(mk_query(13, 32'h7fff_ffff));
    send_req(mk_query(12, $urandom));
  endtask

  task automatic test_random_phases();
    run_phase(0, 64, 150, 1'b0);
    run_phase(64, 64, 150, 1'b1);
    run_phase(127, 127, 150, 1'b0);
    run_phase(3, 127, 150, 1'b0);
    run_phase($urandom_range(0, 64), $urandom_range(0, 64), 150, 1'b0);
    run_phase($urandom_range(0, 127), $urandom_range(1, 127), 150, 1'b0);
  endtask

  // Result side stalls at random, never during a calm phase
  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_samples.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_rsp_o);
      end else begin
        want = due_samples.pop_front();
        if (out_rsp_o.out_x !== want.out_x) begin
          fail_count++;
          $display("%0t: out_x expected %h actual %h", $time, want.out_x, out_rsp_o.out_x);
        end
        if (out_rsp_o.out_y !== want.out_y) begin
          fail_count++;
          $display("%0t: out_y expected %h actual %h", $time, want.out_y, out_rsp_o.out_y);
        end
        if (out_rsp_o.out_z !== want.out_z) begin
          fail_count++;
          $display("%0t: out_z expected %h actual %h", $time, want.out_z, out_rsp_o.out_z);
        end
        if (out_rsp_o.source !== want.source) begin
          fail_count++;
          $display("%0t: source expected %0d actual %0d", $time, want.source,
                   out_rsp_o.source);
        end
      end
    end
  end

  // Watchdog: too long without any transfer
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i))
        stuck = 0;
      else
        stuck++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_tables();
    test_ignored_loads();
    test_constant_hit();
    test_channel_paths();
    test_random_phases();
    settle();
    if (due_samples.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results never arrived", $time, due_samples.size());
    end
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
